// ===== rtl/vci_pkg.sv =====
// Shared types and constants for the vehicle command interlock.
// Holds the input and result word layouts, drive codes and command characters.
// No dependencies.
package vci_pkg;

  localparam logic [2:0] DRV_STOP  = 3'd0;
  localparam logic [2:0] DRV_FWD   = 3'd1;
  localparam logic [2:0] DRV_BWD   = 3'd2;
  localparam logic [2:0] DRV_RIGHT = 3'd3;
  localparam logic [2:0] DRV_LEFT  = 3'd4;

  localparam logic [9:0] DUTY_LOW  = 10'((40 * 1023) / 100);
  localparam logic [9:0] DUTY_HIGH = 10'((95 * 1023) / 100);

  localparam logic [7:0] CMD_FWD       = 8'h46;
  localparam logic [7:0] CMD_BWD       = 8'h42;
  localparam logic [7:0] CMD_RIGHT     = 8'h52;
  localparam logic [7:0] CMD_LEFT      = 8'h4C;
  localparam logic [7:0] CMD_STOP      = 8'h53;
  localparam logic [7:0] CMD_FLAG_UP   = 8'h4D;
  localparam logic [7:0] CMD_FLAG_DOWN = 8'h6D;
  localparam logic [7:0] CMD_DUTY_LOW  = 8'h4E;
  localparam logic [7:0] CMD_DUTY_HIGH = 8'h6E;

  localparam logic REG_LIGHT_THRESHOLD = 1'b0;
  localparam logic REG_OBSTACLE_LIMIT  = 1'b1;

  localparam logic [15:0] LIGHT_THRESHOLD_RST = 16'd65;
  localparam logic [15:0] OBSTACLE_LIMIT_RST  = 16'd7;

  // floor(x/3) for x below 1024 as (x * RECIP_3) >> RECIP_SHIFT
  localparam logic [9:0] RECIP_3     = 10'd683;
  localparam int         RECIP_SHIFT = 11;

  typedef struct packed {
    logic        flame_clear;
    logic [9:0]  light_raw;
    logic [15:0] front_distance;
    logic [15:0] rear_distance;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        button_stop;
  } in_word_t;

  typedef struct packed {
    logic [2:0] motor_drive;
    logic       buzzer_on;
    logic       light_on;
    logic       flag_up;
    logic [9:0] speed_duty;
  } out_word_t;

  typedef struct packed {
    logic [15:0] light_threshold;
    logic [15:0] obstacle_limit;
  } cfg_t;

endpackage

// ===== rtl/vci_regs.sv =====
// Configuration register file with an APB-style write/read port.
// Depends on vci_pkg for the register indexes and the cfg_t bundle.
module vci_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output vci_pkg::cfg_t cfg
);
  import vci_pkg::*;

  logic [15:0] light_threshold_r;
  logic [15:0] obstacle_limit_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_threshold_r <= LIGHT_THRESHOLD_RST;
      obstacle_limit_r  <= OBSTACLE_LIMIT_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_LIGHT_THRESHOLD) begin
        light_threshold_r <= pwdata[15:0];
      end else begin
        obstacle_limit_r <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_OBSTACLE_LIMIT) begin
      prdata = {16'd0, obstacle_limit_r};
    end else begin
      prdata = {16'd0, light_threshold_r};
    end
  end

  assign cfg.light_threshold = light_threshold_r;
  assign cfg.obstacle_limit  = obstacle_limit_r;

endmodule

// ===== rtl/vci_core.sv =====
// Control-pass logic: sensor scaling, obstacle interlock, command decode.
// Holds drive, heading and duty state. Depends on vci_pkg.
module vci_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  vci_pkg::in_word_t  in_word,
  input  vci_pkg::cfg_t      cfg,
  output vci_pkg::out_word_t res_word
);
  import vci_pkg::*;

  logic [2:0]  drive_r, drive_nxt;
  logic [2:0]  heading_r, heading_nxt;
  logic [9:0]  duty_r, duty_nxt;
  logic [19:0] light_prod;
  logic [15:0] light_scaled;
  logic        block_fwd, block_bwd;
  logic        flag;

  assign light_prod   = in_word.light_raw * RECIP_3;
  assign light_scaled = {7'd0, light_prod[RECIP_SHIFT +: 9]} - 16'd1;

  assign block_fwd = (in_word.front_distance != 16'd0) &&
                     (in_word.front_distance < cfg.obstacle_limit);
  assign block_bwd = (in_word.rear_distance != 16'd0) &&
                     (in_word.rear_distance < cfg.obstacle_limit);

  always_comb begin
    drive_nxt   = drive_r;
    heading_nxt = heading_r;
    duty_nxt    = duty_r;
    flag        = block_fwd;
    if ((block_fwd && heading_r == DRV_FWD) || (block_bwd && heading_r == DRV_BWD)) begin
      drive_nxt = DRV_STOP;
    end
    if (in_word.rx_valid) begin
      case (in_word.rx_byte)
        CMD_FWD: begin
          if (!block_fwd) begin
            heading_nxt = DRV_FWD;
            drive_nxt   = DRV_FWD;
          end
        end
        CMD_BWD: begin
          if (!block_bwd) begin
            heading_nxt = DRV_BWD;
            drive_nxt   = DRV_BWD;
          end
        end
        CMD_RIGHT: begin
          heading_nxt = DRV_RIGHT;
          drive_nxt   = DRV_RIGHT;
        end
        CMD_LEFT: begin
          heading_nxt = DRV_LEFT;
          drive_nxt   = DRV_LEFT;
        end
        CMD_STOP: begin
          heading_nxt = DRV_STOP;
          drive_nxt   = DRV_STOP;
        end
        CMD_FLAG_UP:   flag = 1'b1;
        CMD_FLAG_DOWN: flag = 1'b0;
        CMD_DUTY_LOW:  duty_nxt = DUTY_LOW;
        CMD_DUTY_HIGH: duty_nxt = DUTY_HIGH;
        default: ;
      endcase
    end
    if (in_word.button_stop) begin
      drive_nxt = DRV_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r   <= DRV_STOP;
      heading_r <= DRV_STOP;
      duty_r    <= DUTY_LOW;
    end else if (fire) begin
      drive_r   <= drive_nxt;
      heading_r <= heading_nxt;
      duty_r    <= duty_nxt;
    end
  end

  assign res_word.motor_drive = drive_nxt;
  assign res_word.buzzer_on   = ~in_word.flame_clear;
  assign res_word.light_on    = light_scaled > cfg.light_threshold;
  assign res_word.flag_up     = flag;
  assign res_word.speed_duty  = duty_nxt;

endmodule

// ===== rtl/vehicle_command_interlock_unit.sv =====
// Vehicle command interlock top level: input register, control-pass logic,
// result register and configuration port. Depends on vci_pkg, vci_regs, vci_core.
//
// One word in is one control pass, one word out is its result. A word is taken
// every cycle while in_stall is low. The input register takes each accepted word;
// its result goes through the pass logic into the result register, where out_valid
// shows it, once that register is not stalled. in_stall rises only while both
// registers hold words and the result side stalls. Configuration writes land at
// the access cycle of the bus; reads return the register zero-extended to 32 bits.
module vehicle_command_interlock_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vci_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output vci_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import vci_pkg::*;

  in_word_t  in_r;
  logic      in_valid_r;
  out_word_t out_r;
  logic      out_valid_r;
  out_word_t res_word;
  cfg_t      cfg;
  logic      out_hold;
  logic      in_accept;
  logic      fire;

  assign out_hold  = out_valid_r & out_stall;
  assign in_stall  = in_valid_r & out_hold;
  assign in_accept = in_valid & ~in_stall;
  assign fire      = in_valid_r & ~out_hold;

  vci_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vci_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_word  (in_r),
    .cfg      (cfg),
    .res_word (res_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_accept | (in_valid_r & out_hold);
      out_valid_r <= fire | out_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_word;
    end
    if (fire) begin
      out_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// ===== rtl/vci_checker.sv =====
// Port-level checks for vehicle_command_interlock_unit, bound to the top level.
// Depends on vci_pkg for the word types and constants.
module vci_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input vci_pkg::out_word_t out_word
);
  import vci_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_duty_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.speed_duty == DUTY_LOW || out_word.speed_duty == DUTY_HIGH)
    else $error("duty outside the two settings");

  a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.motor_drive <= DRV_LEFT)
    else $error("motor drive code out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind vehicle_command_interlock_unit vci_checker u_vci_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
